// File: sv/hct_pkg.sv
// Shared types and constants for the handheld console timer.
// Holds register addresses, control bit positions and the rate table.
// No dependencies.
package hct_pkg;

   localparam logic [15:0] ADDR_DIV = 16'hFF04;
   localparam logic [15:0] ADDR_TMA = 16'hFF06;
   localparam logic [15:0] ADDR_TAC = 16'hFF07;

   localparam int CTRL_ENABLE_BIT = 2;
   localparam logic [2:0] CTRL_MASK = 3'h7;

   localparam logic [1:0] RATE_1024 = 2'b00;
   localparam logic [1:0] RATE_16   = 2'b01;
   localparam logic [1:0] RATE_64   = 2'b10;
   localparam logic [1:0] RATE_256  = 2'b11;

   // One decoded transaction as it leaves the input register.
   typedef struct packed {
      logic       tick;
      logic       wr_div;
      logic       wr_tma;
      logic       wr_tac;
      logic [7:0] cycles;
      logic [7:0] data;
   } hct_cmd_type;

   function automatic logic [15:0] rate_period(input logic [1:0] rate);
      logic [15:0] period;
      case (rate)
         RATE_1024: period = 16'd1024;
         RATE_16:   period = 16'd16;
         RATE_64:   period = 16'd64;
         default:   period = 16'd256;
      endcase
      return period;
   endfunction

endpackage

// File: sv/hct_div_unit.sv
// Divider register and its cycle accumulator.
// Depends on hct_pkg for the decoded transaction type.
module hct_div_unit
   import hct_pkg::*;
#(
   parameter int DIV_PERIOD = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  hct_cmd_type cmd,
   output logic [7:0]  div_next
);

   // Below 255 the accumulator can grow without bound, so it then wraps at 32 bits.
   localparam int ACC_W = (DIV_PERIOD >= 255) ? $clog2(DIV_PERIOD + 256) : 32;
   localparam logic [ACC_W-1:0] PERIOD = ACC_W'(DIV_PERIOD);

   logic [7:0]       div_ff, div_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [ACC_W-1:0] sum;

   always_comb begin
      sum    = acc_ff + ACC_W'(cmd.cycles);
      div_in = div_ff;
      acc_in = acc_ff;
      if (cmd.tick) begin
         if (sum >= PERIOD) begin
            acc_in = sum - PERIOD;
            div_in = div_ff + 8'd1;
         end else begin
            acc_in = sum;
         end
      end else if (cmd.wr_div) begin
         div_in = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff <= '0;
         acc_ff <= '0;
      end else if (advance) begin
         div_ff <= div_in;
         acc_ff <= acc_in;
      end
   end

   assign div_next = div_in;

endmodule

// File: sv/hct_tima_unit.sv
// Timer counter, modulo and control registers with the counter accumulator.
// Depends on hct_pkg for the transaction type, control bits and rate table.
module hct_tima_unit
   import hct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  hct_cmd_type cmd,
   output logic [7:0]  tima_next,
   output logic [7:0]  tma_next,
   output logic [2:0]  control_next,
   output logic        irq_next
);

   logic [7:0]  tima_ff, tima_in;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  tma_ff, tma_in;
   logic [2:0]  ctrl_ff, ctrl_in;
   logic        irq;
   logic [16:0] sum;
   logic [15:0] sat;
   logic [15:0] period;

   always_comb begin
      sum     = {1'b0, acc_ff} + 17'(cmd.cycles);
      sat     = sum[16] ? 16'hFFFF : sum[15:0];
      period  = rate_period(ctrl_ff[1:0]);
      tima_in = tima_ff;
      acc_in  = acc_ff;
      tma_in  = tma_ff;
      ctrl_in = ctrl_ff;
      irq     = 1'b0;
      if (cmd.tick) begin
         if (ctrl_ff[CTRL_ENABLE_BIT]) begin
            if (sat >= period) begin
               acc_in = sat - period;
               if (tima_ff == 8'hFF) begin
                  tima_in = tma_ff;
                  irq     = 1'b1;
               end else begin
                  tima_in = tima_ff + 8'd1;
               end
            end else begin
               acc_in = sat;
            end
         end
      end else if (cmd.wr_tma) begin
         tma_in = cmd.data;
      end else if (cmd.wr_tac) begin
         ctrl_in = cmd.data[2:0] & CTRL_MASK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tima_ff <= '0;
         acc_ff  <= '0;
         tma_ff  <= '0;
         ctrl_ff <= '0;
      end else if (advance) begin
         tima_ff <= tima_in;
         acc_ff  <= acc_in;
         tma_ff  <= tma_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign tima_next    = tima_in;
   assign tma_next     = tma_in;
   assign control_next = ctrl_in;
   assign irq_next     = irq;

endmodule

// File: sv/handheld_console_timer_core.sv
// Top level of the handheld console timer: input register, decode and result register.
// Depends on hct_pkg, hct_div_unit and hct_tima_unit.
//
// Each request transaction either advances time by a number of cycles
// (req_tuser low) or writes the divider, modulo or control register
// (req_tuser high). Every request yields exactly one response transaction
// carrying the register values after that request and the overflow flag.
// A request is held in the input register and the state update is
// computed from it into the result register, which drives rsp_tvalid.
// One request is taken every cycle while the receiver keeps up; the rate is
// set by the combinational accumulator add, saturate and compare path.
// If the receiver stalls, the result register holds its response and the
// input register keeps one more request, after which req_tready falls.
// Reset clears all timer state to zero (timer disabled, rate code RATE_1024)
// and empties both registers.
module handheld_console_timer_core
   import hct_pkg::*;
#(
   parameter int DIV_PERIOD = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // cycles[7:0], address[23:8], data[31:24]
   input  logic        req_tuser,  // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // div_value[7:0], tima_value[15:8], tma_value[23:16],
                                   // control_value[26:24], timer_irq[27], zero[31:28]
);

   logic        in_valid_ff, in_valid_in;
   logic [31:0] in_data_ff;
   logic        in_func_ff;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_data_ff;
   logic        advance;
   hct_cmd_type cmd;
   logic [15:0] address;
   logic [7:0]  div_next, tima_next, tma_next;
   logic [2:0]  control_next;
   logic        irq_next;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      address    = in_data_ff[23:8];
      cmd.tick   = !in_func_ff;
      cmd.wr_div = in_func_ff && (address == ADDR_DIV);
      cmd.wr_tma = in_func_ff && (address == ADDR_TMA);
      cmd.wr_tac = in_func_ff && (address == ADDR_TAC);
      cmd.cycles = in_data_ff[7:0];
      cmd.data   = in_data_ff[31:24];
   end

   hct_div_unit #(
      .DIV_PERIOD(DIV_PERIOD)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cmd     (cmd),
      .div_next(div_next)
   );

   hct_tima_unit u_tima (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .cmd         (cmd),
      .tima_next   (tima_next),
      .tma_next    (tma_next),
      .control_next(control_next),
      .irq_next    (irq_next)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_func_ff <= req_tuser;
      end
      if (advance) begin
         out_data_ff <= {4'b0000, irq_next, control_next, tma_next, tima_next, div_next};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for handheld_console_timer_core: a directed table and random traffic,
// with each response checked against its row's stated view or a cycle-free divider/timer model.
// Depends on hct_pkg and handheld_console_timer_core.
module tb_top;
   import hct_pkg::*;

   localparam logic FUNC_TICK  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;
   localparam int DIV_CYCLES     = 256;
   localparam int ACCUM_CEILING  = 65535;
   localparam int RANDOM_ITEMS   = 2000;
   localparam int FAST_RUN_ITEMS = 400;
   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      logic       timer_irq;
      logic [2:0] control_value;
      logic [7:0] tma_value;
      logic [7:0] tima_value;
      logic [7:0] div_value;
   } timer_view_type;

   typedef struct packed {
      logic           func;
      logic [7:0]     cycles;
      logic [15:0]    address;
      logic [7:0]     data;
      bit             stated;
      timer_view_type stated_view;
   } timer_req_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;  // cycles[7:0], address[23:8], data[31:24]
   logic        req_tuser;  // func[0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;  // div_value[7:0], tima_value[15:8], tma_value[23:16],
                            // control_value[26:24], timer_irq[27], zero[31:28]

   logic [7:0]  div_reg = '0;
   int          div_accum = 0;
   logic [7:0]  tima_reg = '0;
   int          tima_accum = 0;
   logic [7:0]  tma_reg = '0;
   logic [2:0]  tac_reg = '0;

   timer_req_type  offered_items[$];
   timer_view_type expected_regs[$];
   timer_req_type  directed_reqs[$];
   int             req_count = 0;
   int             errors = 0;
   int             quiet_cycles = 0;
   logic           calm;

   assign calm = (req_count >= 1000) && (req_count < 1300);

   handheld_console_timer_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic timer_view_type predict_timer_step(timer_req_type rec);
      timer_view_type view;
      int period;
      logic overflow;
      overflow = 1'b0;
      if (rec.func == FUNC_TICK) begin
         div_accum = div_accum + rec.cycles;
         if (div_accum >= DIV_CYCLES) begin
            div_accum = div_accum - DIV_CYCLES;
            div_reg = div_reg + 8'd1;
         end
         if (tac_reg[CTRL_ENABLE_BIT]) begin
            case (tac_reg[1:0])
               RATE_1024: period = 1024;
               RATE_16:   period = 16;
               RATE_64:   period = 64;
               default:   period = 256;
            endcase
            tima_accum = tima_accum + rec.cycles;
            if (tima_accum > ACCUM_CEILING) tima_accum = ACCUM_CEILING;
            if (tima_accum >= period) begin
               tima_accum = tima_accum - period;
               if (tima_reg == 8'hFF) begin
                  tima_reg = tma_reg;
                  overflow = 1'b1;
               end else begin
                  tima_reg = tima_reg + 8'd1;
               end
            end
         end
      end else begin
         case (rec.address)
            ADDR_DIV: div_reg = '0;
            ADDR_TMA: tma_reg = rec.data;
            ADDR_TAC: tac_reg = rec.data[2:0] & CTRL_MASK;
            default: ;
         endcase
      end
      view.div_value     = div_reg;
      view.tima_value    = tima_reg;
      view.tma_value     = tma_reg;
      view.control_value = tac_reg;
      view.timer_irq     = overflow;
      return view;
   endfunction

   function automatic timer_view_type view_of(logic [7:0] div_value, logic [7:0] tima_value,
                                              logic [7:0] tma_value, logic [2:0] control_value);
      timer_view_type view;
      view.div_value     = div_value;
      view.tima_value    = tima_value;
      view.tma_value     = tma_value;
      view.control_value = control_value;
      view.timer_irq     = 1'b0;
      return view;
   endfunction

   function automatic void table_row(logic func, logic [7:0] cycles, logic [15:0] address,
                                     logic [7:0] data, bit stated = 1'b0,
                                     timer_view_type view = '0);
      timer_req_type rec;
      rec.func        = func;
      rec.cycles      = cycles;
      rec.address     = address;
      rec.data        = data;
      rec.stated      = stated;
      rec.stated_view = view;
      directed_reqs.push_back(rec);
   endfunction

   function automatic timer_req_type random_tick(int lo, int hi);
      timer_req_type rec;
      rec         = '0;
      rec.func    = FUNC_TICK;
      rec.cycles  = 8'($urandom_range(hi, lo));
      rec.address = 16'($urandom);
      rec.data    = 8'($urandom);
      return rec;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endfunction

   task automatic send_item(timer_req_type rec);
      while (!calm && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      offered_items.push_back(rec);
      req_tvalid <= 1'b1;
      req_tuser  <= rec.func;
      req_tdata  <= {rec.data, rec.address, rec.cycles};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   always @(posedge clock) begin : monitor
      timer_req_type  rec;
      timer_view_type want;
      timer_view_type got;
      logic           moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_tvalid && req_tready) begin
            rec  = offered_items.pop_front();
            want = predict_timer_step(rec);
            if (rec.stated) want = rec.stated_view;
            expected_regs.push_back(want);
            req_count++;
            moved = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (expected_regs.size() == 0) begin
               $error("response transaction 0x%08h arrived with nothing outstanding", rsp_tdata);
               errors++;
            end else begin
               want = expected_regs.pop_front();
               got  = rsp_tdata[27:0];
               check_field("div_value", want.div_value, got.div_value);
               check_field("tima_value", want.tima_value, got.tima_value);
               check_field("tma_value", want.tma_value, got.tma_value);
               check_field("control_value", want.control_value, got.control_value);
               check_field("timer_irq", want.timer_irq, got.timer_irq);
               check_field("pad", 0, rsp_tdata[31:28]);
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("handheld_console_timer_core regression: fail");
            $finish;
         end
      end
   end

   initial begin : receiver
      int hold_at;
      hold_at = 300;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (req_count >= hold_at) begin
            hold_at = hold_at + 1200;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= 11);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      timer_req_type rec;
      int issued;
      int phase_len;
      int pick;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Ticks ignore address and data; writes ignore cycles.
      table_row(FUNC_TICK,  8'h00, 16'hFFFF, 8'hFF, 1'b1, view_of(8'h00, 8'h00, 8'h00, 3'd0));
      table_row(FUNC_TICK,  8'hFF, ADDR_DIV, 8'h00, 1'b1, view_of(8'h00, 8'h00, 8'h00, 3'd0));
      table_row(FUNC_TICK,  8'h01, ADDR_TAC, 8'hFF, 1'b1, view_of(8'h01, 8'h00, 8'h00, 3'd0));
      table_row(FUNC_WRITE, 8'hFF, ADDR_DIV, 8'hFF, 1'b1, view_of(8'h00, 8'h00, 8'h00, 3'd0));
      table_row(FUNC_WRITE, 8'h00, ADDR_TMA, 8'hFF, 1'b1, view_of(8'h00, 8'h00, 8'hFF, 3'd0));
      table_row(FUNC_WRITE, 8'h00, 16'hFF05, 8'h55, 1'b1, view_of(8'h00, 8'h00, 8'hFF, 3'd0));
      table_row(FUNC_WRITE, 8'hFF, 16'h0000, 8'h00, 1'b1, view_of(8'h00, 8'h00, 8'hFF, 3'd0));
      table_row(FUNC_WRITE, 8'h00, 16'hFFFF, 8'hFF, 1'b1, view_of(8'h00, 8'h00, 8'hFF, 3'd0));
      table_row(FUNC_WRITE, 8'h00, ADDR_TAC, {5'h1F, 1'b0, RATE_1024}, 1'b1,
                view_of(8'h00, 8'h00, 8'hFF, {1'b0, RATE_1024}));
      table_row(FUNC_WRITE, 8'h00, ADDR_TAC, {5'h1F, 1'b1, RATE_16}, 1'b1,
                view_of(8'h00, 8'h00, 8'hFF, {1'b1, RATE_16}));
      table_row(FUNC_TICK,  8'h0F, 16'h0000, 8'h00, 1'b1,
                view_of(8'h00, 8'h00, 8'hFF, {1'b1, RATE_16}));
      table_row(FUNC_TICK,  8'h01, 16'h0000, 8'h00, 1'b1,
                view_of(8'h00, 8'h01, 8'hFF, {1'b1, RATE_16}));
      table_row(FUNC_TICK,  8'hFF, 16'h1234, 8'hA5);
      table_row(FUNC_WRITE, 8'h00, ADDR_TMA, 8'h00);
      table_row(FUNC_WRITE, 8'h00, ADDR_TAC, {5'h00, 1'b1, RATE_64});
      table_row(FUNC_TICK,  8'h80, 16'h0000, 8'h00);
      table_row(FUNC_WRITE, 8'h00, ADDR_TAC, {5'h00, 1'b0, RATE_256});
      table_row(FUNC_TICK,  8'hFF, 16'h0000, 8'h00);
      table_row(FUNC_WRITE, 8'h00, ADDR_TAC, {5'h00, 1'b1, RATE_256});
      table_row(FUNC_TICK,  8'hFF, 16'h0000, 8'h00);
      table_row(FUNC_TICK,  8'hFF, 16'h0000, 8'h00);
      table_row(FUNC_WRITE, 8'h00, ADDR_TAC, {5'h00, 1'b1, RATE_1024});
      table_row(FUNC_TICK,  8'hFF, 16'hFF07, 8'h03);
      table_row(FUNC_WRITE, 8'h00, ADDR_DIV, 8'h00);
      table_row(FUNC_WRITE, 8'h00, ADDR_TAC, 8'h00);

      foreach (directed_reqs[i]) send_item(directed_reqs[i]);

      // The first phase runs the fast rate long enough to wrap the counter
      // and pin its accumulator at the ceiling.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         if (issued == 0 || $urandom_range(5) == 0) begin
            rec         = '0;
            rec.func    = FUNC_WRITE;
            rec.address = ADDR_TAC;
            rec.cycles  = 8'($urandom);
            rec.data    = {5'($urandom), 1'b1, RATE_16};
            send_item(rec);
            issued++;
            repeat (FAST_RUN_ITEMS) begin
               send_item(random_tick(200, 255));
               issued++;
            end
         end else begin
            phase_len = $urandom_range(300, 150);
            repeat (phase_len) begin
               if ($urandom_range(99) < 15) begin
                  rec        = '0;
                  rec.func   = FUNC_WRITE;
                  rec.cycles = 8'($urandom);
                  rec.data   = 8'($urandom);
                  pick       = $urandom_range(99);
                  if (pick < 30) begin
                     rec.address = ADDR_TAC;
                     rec.data[CTRL_ENABLE_BIT] = ($urandom_range(3) != 0);
                  end else if (pick < 55) begin
                     rec.address = ADDR_TMA;
                     if ($urandom_range(1) == 1) rec.data = 8'($urandom_range(255, 240));
                  end else if (pick < 70) begin
                     rec.address = ADDR_DIV;
                  end else begin
                     rec.address = 16'($urandom);
                  end
               end else if ($urandom_range(9) == 0) begin
                  rec = ($urandom_range(1) == 1) ? random_tick(255, 255) : random_tick(0, 0);
               end else begin
                  rec = random_tick(0, 255);
               end
               send_item(rec);
               issued++;
            end
         end
      end
      req_tvalid <= 1'b0;

      while (expected_regs.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("handheld_console_timer_core regression: pass");
      end else begin
         $display("handheld_console_timer_core regression: fail");
      end
      $finish;
   end

endmodule
